FILE: src/imu_startup_offset_calibration_defines.svh
// ----------------------------------------------------------------------------
// imu startup offset calibration assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef IMU_STARTUP_OFFSET_CALIBRATION_DEFINES_SVH
`define IMU_STARTUP_OFFSET_CALIBRATION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication under reset
`define IMUSOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imusoc check failed");

// next-cycle implication under reset
`define IMUSOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imusoc check failed");

`else

`define IMUSOC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IMUSOC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/imusoc_pkg.sv
// ----------------------------------------------------------------------------
// imusoc_pkg
// shared types and constants of the imu startup offset calibration block
// ----------------------------------------------------------------------------
package imusoc_pkg;

    localparam int AXES         = 6;
    localparam int ACCEL_Z_AXIS = 5;
    localparam int SAMPLE_W     = 16;
    localparam int GRAVITY_W    = 15;
    localparam int PHASE_W      = 11;
    localparam int SUM_W        = 21;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 15'd16384;

    // word class set by the front part
    localparam logic [1:0] KIND_PASS = 2'd0;  // calibration, outside the window
    localparam logic [1:0] KIND_SUM  = 2'd1;  // calibration, inside the window
    localparam logic [1:0] KIND_LAST = 2'd2;  // final calibration word
    localparam logic [1:0] KIND_CORR = 2'd3;  // corrected word

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_x_in;
        logic signed [SAMPLE_W-1:0] gyro_y_in;
        logic signed [SAMPLE_W-1:0] gyro_z_in;
        logic signed [SAMPLE_W-1:0] accel_x_in;
        logic signed [SAMPLE_W-1:0] accel_y_in;
        logic signed [SAMPLE_W-1:0] accel_z_in;
    } t_imu_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_x_out;
        logic signed [SAMPLE_W-1:0] gyro_y_out;
        logic signed [SAMPLE_W-1:0] gyro_z_out;
        logic signed [SAMPLE_W-1:0] accel_x_out;
        logic signed [SAMPLE_W-1:0] accel_y_out;
        logic signed [SAMPLE_W-1:0] accel_z_out;
        logic                       hold;
    } t_imu_out;

    typedef struct packed {
        logic [1:0] kind;
        t_imu_in    sample;
    } t_queue_word;

endpackage

FILE: src/imusoc_front.sv
// ----------------------------------------------------------------------------
// imusoc_front
// accepts sample words, counts the calibration phase and tags each word
// ----------------------------------------------------------------------------
module imusoc_front #(
    parameter int CAL_SAMPLES = 1000,
    parameter int AVG_WINDOW  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  imusoc_pkg::t_imu_in   i_in_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output imusoc_pkg::t_queue_word o_push_word
);
    import imusoc_pkg::*;

    localparam int WIN_START = (AVG_WINDOW >= CAL_SAMPLES) ? 0 : CAL_SAMPLES - AVG_WINDOW;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [1:0]         w_kind;

    // accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // classify by position in the calibration phase
    always_comb begin
        if (r_phase == PHASE_W'(CAL_SAMPLES)) begin
            w_kind = KIND_CORR;
        end else if (r_phase == PHASE_W'(CAL_SAMPLES - 1)) begin
            w_kind = KIND_LAST;
        end else if (r_phase >= PHASE_W'(WIN_START)) begin
            w_kind = KIND_SUM;
        end else begin
            w_kind = KIND_PASS;
        end
    end

    assign o_push_word.kind   = w_kind;
    assign o_push_word.sample = i_in_data;

    // phase counter stops at the end of calibration
    always_comb begin
        n_phase = r_phase;
        if (o_push && (r_phase != PHASE_W'(CAL_SAMPLES))) begin
            n_phase = r_phase + PHASE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

FILE: src/imusoc_queue.sv
// ----------------------------------------------------------------------------
// imusoc_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
module imusoc_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  imusoc_pkg::t_queue_word i_push_word,
    input  logic                    i_pop,
    output logic                    o_valid,
    output logic                    o_full,
    output imusoc_pkg::t_queue_word o_head
);
    import imusoc_pkg::*;

    t_queue_word        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_word;
        end
    end

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: src/imusoc_back.sv
// ----------------------------------------------------------------------------
// imusoc_back
// window sums, offset division, correction and the output register
// ----------------------------------------------------------------------------
`include "imu_startup_offset_calibration_defines.svh"

module imusoc_back #(
    parameter int AVG_WINDOW = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  imusoc_pkg::t_queue_word     i_q_head,
    output logic                        o_pop,
    input  logic [imusoc_pkg::GRAVITY_W-1:0] i_gravity,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output imusoc_pkg::t_imu_out        o_out_data
);
    import imusoc_pkg::*;

    // reciprocal of the window length, exact for every sum magnitude below 2^SUM_W
    localparam int     DIV_SHIFT = SUM_W + $clog2(AVG_WINDOW);
    localparam int     RECIP_W   = SUM_W + 2;
    localparam int     PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP     = ((longint'(1) << DIV_SHIFT) + longint'(AVG_WINDOW) - 1)
                                   / longint'(AVG_WINDOW);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic signed [SAMPLE_W-1:0] w_s     [AXES];
    logic signed [SAMPLE_W-1:0] w_res   [AXES];
    logic signed [SUM_W-1:0]    w_sum   [AXES];
    logic [SUM_W-1:0]           w_mag   [AXES];
    logic [PROD_W-1:0]          w_prod  [AXES];
    logic [SUM_W-1:0]           w_quo   [AXES];
    logic [SUM_W-1:0]           w_qsgn  [AXES];

    logic signed [SUM_W-1:0]    r_sums  [AXES];  // window sums, then their magnitude
    logic                       r_neg   [AXES];
    logic signed [SAMPLE_W-1:0] r_off   [AXES];
    logic                       r_div_busy;
    logic                       r_cal_done;
    logic                       r_out_valid;
    t_imu_out                   r_out;
    t_imu_out                   n_out;
    logic                       w_corr;
    logic                       w_pop_last;

    // head word split into axes
    assign w_s[0] = i_q_head.sample.gyro_x_in;
    assign w_s[1] = i_q_head.sample.gyro_y_in;
    assign w_s[2] = i_q_head.sample.gyro_z_in;
    assign w_s[3] = i_q_head.sample.accel_x_in;
    assign w_s[4] = i_q_head.sample.accel_y_in;
    assign w_s[5] = i_q_head.sample.accel_z_in;

    // take a word when the divider is idle and the output register frees up
    assign o_pop      = i_q_valid && !r_div_busy && (!r_out_valid || i_out_ready);
    assign w_corr     = (i_q_head.kind == KIND_CORR);
    assign w_pop_last = o_pop && (i_q_head.kind == KIND_LAST);

    // per-axis datapath: accumulate, reciprocal divide, correct
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_sum[a]  = r_sums[a] + {{(SUM_W-SAMPLE_W){w_s[a][SAMPLE_W-1]}}, w_s[a]};
            w_mag[a]  = w_sum[a][SUM_W-1] ? SUM_W'(-w_sum[a]) : SUM_W'(w_sum[a]);
            w_prod[a] = {{RECIP_W{1'b0}}, r_sums[a]} * {{SUM_W{1'b0}}, RECIP_V};
            w_quo[a]  = SUM_W'(w_prod[a] >> DIV_SHIFT);
            w_qsgn[a] = r_neg[a] ? (~w_quo[a] + SUM_W'(1)) : w_quo[a];
            w_res[a]  = w_s[a] - r_off[a];
        end
        w_res[ACCEL_Z_AXIS] = w_s[ACCEL_Z_AXIS] - r_off[ACCEL_Z_AXIS]
                            + $signed({1'b0, i_gravity});
    end

    // result word: raw during calibration, corrected afterwards
    always_comb begin
        n_out.gyro_x_out  = w_corr ? w_res[0] : w_s[0];
        n_out.gyro_y_out  = w_corr ? w_res[1] : w_s[1];
        n_out.gyro_z_out  = w_corr ? w_res[2] : w_s[2];
        n_out.accel_x_out = w_corr ? w_res[3] : w_s[3];
        n_out.accel_y_out = w_corr ? w_res[4] : w_s[4];
        n_out.accel_z_out = w_corr ? w_res[5] : w_s[5];
        n_out.hold        = !w_corr;
    end

    // sums, offset division in the busy state and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sums[a] <= '0;
                r_neg[a]  <= 1'b0;
                r_off[a]  <= '0;
            end
            r_div_busy <= 1'b0;
            r_cal_done <= 1'b0;
        end else if (r_div_busy) begin
            for (int a = 0; a < AXES; a++) begin
                r_off[a] <= w_qsgn[a][SAMPLE_W-1:0];
            end
            r_div_busy <= 1'b0;
            r_cal_done <= 1'b1;
        end else if (o_pop) begin
            case (i_q_head.kind)
                KIND_SUM: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_sums[a] <= w_sum[a];
                    end
                end
                KIND_LAST: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_sums[a] <= w_mag[a];
                        r_neg[a]  <= w_sum[a][SUM_W-1];
                    end
                    r_div_busy <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `IMUSOC_ASSERT_NOW(a_no_pop_in_div, i_clk, i_rst_n, r_div_busy, !o_pop)
    `IMUSOC_ASSERT_NOW(a_corr_after_cal, i_clk, i_rst_n, o_pop && w_corr, r_cal_done)
    `IMUSOC_ASSERT_NEXT(a_last_starts_div, i_clk, i_rst_n, w_pop_last, r_div_busy)
    `IMUSOC_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_cal_done, !r_div_busy)

endmodule

FILE: src/imu_startup_offset_calibration.sv
// ----------------------------------------------------------------------------
// imu_startup_offset_calibration
// startup zero-offset calibration for a six-axis inertial sensor
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_ready   | t_imu_in, six signed axes
//  out     | output    | o_out_valid / i_out_ready | t_imu_out, six axes and hold
//  cfg     | input     | i_cfg_valid / o_cfg_ready | gravity count, 15 bits
//
//  sustained rate one word per cycle while the divider is idle; an accepted
//  word goes via the queue to the output register when the output is free
//  while the busy state after the last calibration word computes offsets, a
//  reciprocal multiply per axis, corrected words wait in the 4-entry queue
//  reset is synchronous, active low; it restarts the calibration phase
//  output stalls back up into the queue; input stalls only when it is full
// ----------------------------------------------------------------------------
module imu_startup_offset_calibration #(
    parameter int CAL_SAMPLES = 1000,
    parameter int AVG_WINDOW  = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  imusoc_pkg::t_imu_in              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output imusoc_pkg::t_imu_out             o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [imusoc_pkg::GRAVITY_W-1:0] i_cfg_data
);
    import imusoc_pkg::*;

    logic                 w_q_full;
    logic                 w_q_valid;
    logic                 w_push;
    logic                 w_pop;
    t_queue_word          w_push_word;
    t_queue_word          w_q_head;
    logic [GRAVITY_W-1:0] r_gravity;

    // gravity count register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg_valid) begin
            r_gravity <= i_cfg_data;
        end
    end

    // front: accept and classify
    imusoc_front #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .AVG_WINDOW  (AVG_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_word (w_push_word)
    );

    // queue between the two parts
    imusoc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_word (w_push_word),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_full      (w_q_full),
        .o_head      (w_q_head)
    );

    // back: sums, offsets, correction
    imusoc_back #(
        .AVG_WINDOW (AVG_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .i_gravity   (r_gravity),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
